@@ hw/rtl/external_interrupt_line_controller_defines.svh @@
// Assertion macros for the external interrupt line controller.
`ifndef EXTERNAL_INTERRUPT_LINE_CONTROLLER_DEFINES_SVH
`define EXTERNAL_INTERRUPT_LINE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EILC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define EILC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/exti_pkg.sv @@
// Shared constants, types and register codes for the external interrupt controller.
package exti_pkg;

    localparam int NUM_LINES   = 16;
    localparam int NUM_PORTS   = 8;
    localparam int INPUT_PORTS = 8;
    localparam int LVL_W       = 16;
    localparam int SEL_W       = 4;
    localparam int PSEL_W      = $clog2(INPUT_PORTS);
    localparam int SEL_LIMIT   = (NUM_PORTS < INPUT_PORTS) ? NUM_PORTS : INPUT_PORTS;
    localparam int IRQ_W       = 7;
    localparam int LOW_LINES   = 5;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int PSEL_REG_W  = SEL_W * LVL_W;

    localparam int IN_TDATA_W  = LVL_W + INPUT_PORTS * LVL_W;
    localparam int OUT_RAW_W   = LVL_W + IRQ_W + LVL_W;
    localparam int OUT_TDATA_W = ((OUT_RAW_W + 7) / 8) * 8;

    localparam logic [LVL_W-1:0] LINE_MASK       = LVL_W'((32'd1 << NUM_LINES) - 32'd1);
    localparam logic [LVL_W-1:0] GROUP_MID_MASK  = 16'h03E0;
    localparam logic [LVL_W-1:0] GROUP_HIGH_MASK = 16'hFC00;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_INT_MASK   = 3'd0,
        REG_EVT_MASK   = 3'd1,
        REG_RISE_TRIG  = 3'd2,
        REG_FALL_TRIG  = 3'd3,
        REG_PORT_SEL   = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [SEL_W-1:0] sel;
        logic             rise_en;
        logic             fall_en;
    } t_lane_cfg;

    typedef struct packed {
        logic cur;
        logic trig;
    } t_lane_out;

    typedef struct packed {
        logic [LVL_W-1:0] events;
        logic [IRQ_W-1:0] irq;
        logic [LVL_W-1:0] pending;
    } t_result;

endpackage

@@ hw/rtl/exti_lane.sv @@
// One line: source port select, edge detect against the stored level, trigger enable.
module exti_lane (
    input  logic [exti_pkg::INPUT_PORTS-1:0] i_pins,
    input  exti_pkg::t_lane_cfg              i_cfg,
    input  logic                             i_prev,
    output exti_pkg::t_lane_out              o_lane
);
    import exti_pkg::*;

    logic w_sel_ok;
    logic w_cur;
    logic w_rise;
    logic w_fall;

    assign w_sel_ok = ({1'b0, i_cfg.sel} < (SEL_W + 1)'(SEL_LIMIT));
    assign w_cur    = w_sel_ok & i_pins[i_cfg.sel[PSEL_W-1:0]];
    assign w_rise   = w_cur & ~i_prev;
    assign w_fall   = ~w_cur & i_prev;

    assign o_lane.cur  = w_cur;
    assign o_lane.trig = (w_rise & i_cfg.rise_en) | (w_fall & i_cfg.fall_en);

endmodule

@@ hw/rtl/exti_merge.sv @@
// Merges lane results: pending update, event gating, grouped interrupt requests.
module exti_merge (
    input  logic                        i_func,
    input  logic [exti_pkg::LVL_W-1:0]  i_clear,
    input  logic [exti_pkg::LVL_W-1:0]  i_cur,
    input  logic [exti_pkg::LVL_W-1:0]  i_trig,
    input  logic [exti_pkg::LVL_W-1:0]  i_pending,
    input  logic [exti_pkg::LVL_W-1:0]  i_prev,
    input  logic [exti_pkg::LVL_W-1:0]  i_int_mask,
    input  logic [exti_pkg::LVL_W-1:0]  i_evt_mask,
    output logic [exti_pkg::LVL_W-1:0]  o_pending,
    output logic [exti_pkg::LVL_W-1:0]  o_prev,
    output exti_pkg::t_result           o_result
);
    import exti_pkg::*;

    logic [LVL_W-1:0] w_trig;
    logic [LVL_W-1:0] w_masked;
    logic [LVL_W-1:0] w_events;

    assign w_trig = i_trig & LINE_MASK;

    always_comb begin
        if (i_func == FUNC_CLEAR) begin
            o_pending = i_pending & ~i_clear & LINE_MASK;
            o_prev    = i_prev;
            w_events  = '0;
        end else begin
            o_pending = (i_pending | w_trig) & LINE_MASK;
            o_prev    = i_cur & LINE_MASK;
            w_events  = w_trig & i_evt_mask;
        end
    end

    assign w_masked         = o_pending & i_int_mask;
    assign o_result.events  = w_events;
    assign o_result.pending = o_pending;
    assign o_result.irq     = {|(w_masked & GROUP_HIGH_MASK),
                               |(w_masked & GROUP_MID_MASK),
                               w_masked[LOW_LINES-1:0]};

endmodule

@@ hw/rtl/external_interrupt_line_controller.sv @@
// External interrupt line controller top level: config registers, lanes, state, output stage.
//
// Input stream (s_axis): one transaction per sample tick or clear command.
//   tuser selects the function: tick samples the pin levels of all ports,
//   clear drops the pending bits written as one.
// Output stream (m_axis): exactly one result transaction per input transaction,
//   in order: pending register after the item, grouped interrupt requests
//   (lines 0-4 alone, 5-9 ORed, 10-15 ORed) and the masked event pulses.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_addr
//   (0 interrupt mask, 1 event mask, 2 rising trigger, 3 falling trigger,
//   4 port select, four bits per line). Write only while idle.
// Throughput: one item per cycle while input ready is high; all sixteen lines are
//   evaluated in parallel lanes and the state update closes in that same cycle.
// Stall: a two-entry output stage (output register plus skid register) keeps
//   input ready while one result waits; ready drops only when both are full.
// Reset: synchronous, active low; clears config, previous levels, pending and
//   the output stage valid flags. Levels start low, so a pin high on the first tick is a
//   rising edge.
module external_interrupt_line_controller (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // clear_bits, port0_levels .. port7_levels
    input  logic [exti_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // func
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // pending_bits, irq_lines, event_pulses, zero pad
    output logic [exti_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                              i_cfg_we,
    input  logic [exti_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [exti_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import exti_pkg::*;
    `include "external_interrupt_line_controller_defines.svh"

    logic [LVL_W-1:0]      r_int_mask;
    logic [LVL_W-1:0]      r_evt_mask;
    logic [LVL_W-1:0]      r_rise_trig;
    logic [LVL_W-1:0]      r_fall_trig;
    logic [PSEL_REG_W-1:0] r_port_sel;

    logic [LVL_W-1:0]      r_prev;
    logic [LVL_W-1:0]      r_pending;
    logic [LVL_W-1:0]      n_prev;
    logic [LVL_W-1:0]      n_pending;

    logic                  r_out_valid;
    logic                  r_skid_valid;
    t_result               r_out;
    t_result               r_skid;
    t_result               n_result;

    logic                  w_acc;
    logic                  w_take;
    logic [LVL_W-1:0]      w_cur;
    logic [LVL_W-1:0]      w_trig;
    logic [LVL_W-1:0]      w_port [INPUT_PORTS];

    assign o_s_axis_tready = ~r_skid_valid;
    assign o_m_axis_tvalid = r_out_valid;
    assign w_acc           = i_s_axis_tvalid & o_s_axis_tready;
    assign w_take          = r_out_valid & i_m_axis_tready;
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_out);

    for (genvar p = 0; p < INPUT_PORTS; p++) begin : g_port
        assign w_port[p] = i_s_axis_tdata[LVL_W + p*LVL_W +: LVL_W];
    end

    for (genvar n = 0; n < LVL_W; n++) begin : g_line
        if (n < NUM_LINES) begin : g_lane
            logic [INPUT_PORTS-1:0] w_pins;
            t_lane_cfg              w_cfg;
            t_lane_out              w_lane;

            for (genvar p = 0; p < INPUT_PORTS; p++) begin : g_pin
                assign w_pins[p] = w_port[p][n];
            end

            assign w_cfg.sel     = r_port_sel[n*SEL_W +: SEL_W];
            assign w_cfg.rise_en = r_rise_trig[n];
            assign w_cfg.fall_en = r_fall_trig[n];

            exti_lane u_lane (
                .i_pins (w_pins),
                .i_cfg  (w_cfg),
                .i_prev (r_prev[n]),
                .o_lane (w_lane)
            );

            assign w_cur[n]  = w_lane.cur;
            assign w_trig[n] = w_lane.trig;
        end else begin : g_idle
            assign w_cur[n]  = 1'b0;
            assign w_trig[n] = 1'b0;
        end
    end

    exti_merge u_merge (
        .i_func     (i_s_axis_tuser),
        .i_clear    (i_s_axis_tdata[LVL_W-1:0]),
        .i_cur      (w_cur),
        .i_trig     (w_trig),
        .i_pending  (r_pending),
        .i_prev     (r_prev),
        .i_int_mask (r_int_mask),
        .i_evt_mask (r_evt_mask),
        .o_pending  (n_pending),
        .o_prev     (n_prev),
        .o_result   (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_int_mask  <= '0;
            r_evt_mask  <= '0;
            r_rise_trig <= '0;
            r_fall_trig <= '0;
            r_port_sel  <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_INT_MASK:  r_int_mask  <= i_cfg_data[LVL_W-1:0];
                REG_EVT_MASK:  r_evt_mask  <= i_cfg_data[LVL_W-1:0];
                REG_RISE_TRIG: r_rise_trig <= i_cfg_data[LVL_W-1:0];
                REG_FALL_TRIG: r_fall_trig <= i_cfg_data[LVL_W-1:0];
                REG_PORT_SEL:  r_port_sel  <= i_cfg_data[PSEL_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_pending <= '0;
        end else if (w_acc) begin
            r_prev    <= n_prev;
            r_pending <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !w_take) begin
            if (w_acc) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !w_take) begin
            if (w_acc) begin
                r_skid <= n_result;
            end
        end else if (r_skid_valid) begin
            r_out <= r_skid;
        end else if (w_acc) begin
            r_out <= n_result;
        end
    end

    `EILC_ASSERT_NOW(a_skid_behind_out, r_skid_valid, r_out_valid,
        "skid register holds a result while the output register is empty")
    `EILC_ASSERT_NEXT(a_clear_done, w_acc && (i_s_axis_tuser == FUNC_CLEAR),
        (r_pending & $past(i_s_axis_tdata[LVL_W-1:0])) == '0,
        "pending bit survived a clear")
    `EILC_ASSERT_NEXT(a_drain, w_take && !r_skid_valid && !w_acc, !o_m_axis_tvalid,
        "output stays valid after its only result was taken")
    `EILC_ASSERT_NOW(a_event_pending, r_out_valid,
        (r_out.events & ~r_out.pending) == '0,
        "event pulse without matching pending bit")

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the external interrupt line controller, with line model and stream scoreboard.
module tb;
    import exti_pkg::*;

    localparam int LEVELS_W    = INPUT_PORTS * LVL_W;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 270;

    logic                   i_clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_valid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    logic                   s_user = FUNC_TICK;
    logic                   m_ready = 1'b0;
    logic                   cfg_we = 1'b0;
    t_cfg_reg               cfg_addr = REG_INT_MASK;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    wire                    s_ready;
    wire                    m_valid;
    wire  [OUT_TDATA_W-1:0] m_data;

    // shadow copy of the configuration and line state
    logic [LVL_W-1:0]       int_mask_q = '0;
    logic [LVL_W-1:0]       evt_mask_q = '0;
    logic [LVL_W-1:0]       rise_trig_q = '0;
    logic [LVL_W-1:0]       fall_trig_q = '0;
    logic [PSEL_REG_W-1:0]  port_sel_q = '0;
    logic [LVL_W-1:0]       last_levels_q = '0;
    logic [LVL_W-1:0]       pending_q = '0;

    t_result                results_due[$];
    int                     mismatches = 0;
    int                     cycle_count = 0;
    logic                   calm = 1'b0;
    logic [LEVELS_W-1:0]    last_pins = '0;

    external_interrupt_line_controller dut (
        .i_clk           (i_clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_result compute_irq_result(input logic fn, input logic [LVL_W-1:0] clr,
                                                   input logic [LEVELS_W-1:0] pins);
        t_result          r;
        logic [LVL_W-1:0] cur;
        logic [LVL_W-1:0] trig;
        logic [LVL_W-1:0] masked;
        int               sel;
        r = '0;
        if (fn == FUNC_CLEAR) begin
            pending_q = pending_q & ~clr & LINE_MASK;
        end else begin
            cur = '0;
            for (int n = 0; n < NUM_LINES; n++) begin
                sel = int'(port_sel_q[SEL_W*n +: SEL_W]);
                if (sel < SEL_LIMIT)
                    cur[n] = pins[sel*LVL_W + n];
            end
            cur = cur & LINE_MASK;
            trig = ((cur & ~last_levels_q & rise_trig_q) | (~cur & last_levels_q & fall_trig_q))
                   & LINE_MASK;
            pending_q = (pending_q | trig) & LINE_MASK;
            r.events = trig & evt_mask_q;
            last_levels_q = cur;
        end
        masked = pending_q & int_mask_q;
        r.pending = pending_q;
        r.irq = {|(masked & GROUP_HIGH_MASK), |(masked & GROUP_MID_MASK),
                 masked[LOW_LINES-1:0]};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [LVL_W-1:0] want,
                                   input logic [LVL_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
    endtask

    // input acceptance, output checking and run limit
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            if (rst_n && s_valid && s_ready)
                results_due.push_back(compute_irq_result(s_user, s_data[LVL_W-1:0],
                                                         s_data[IN_TDATA_W-1:LVL_W]));
            if (rst_n && m_valid && m_ready) begin
                got = t_result'(m_data[OUT_RAW_W-1:0]);
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected transaction", '0, got.pending);
                end else begin
                    want = results_due.pop_front();
                    if (got.pending !== want.pending)
                        report_mismatch("pending_bits", want.pending, got.pending);
                    if (got.irq !== want.irq)
                        report_mismatch("irq_lines", LVL_W'(want.irq), LVL_W'(got.irq));
                    if (got.events !== want.events)
                        report_mismatch("event_pulses", want.events, got.events);
                end
            end
        end
    end

    always @(posedge i_clk)
        m_ready <= calm || ($urandom_range(0, 99) >= 27);

    task automatic send_item(input logic fn, input logic [LVL_W-1:0] clr,
                             input logic [LEVELS_W-1:0] pins);
        while (!calm && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= fn;
        s_data  <= {pins, clr};
        do @(posedge i_clk); while (!s_ready);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge i_clk);
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // writes all five registers; only called while the block is idle
    task automatic configure(input logic [LVL_W-1:0] imask, input logic [LVL_W-1:0] emask,
                             input logic [LVL_W-1:0] rise, input logic [LVL_W-1:0] fall,
                             input logic [PSEL_REG_W-1:0] psel);
        logic [CFG_DATA_W-1:0] vals[5];
        vals[REG_INT_MASK]  = CFG_DATA_W'(imask);
        vals[REG_EVT_MASK]  = CFG_DATA_W'(emask);
        vals[REG_RISE_TRIG] = CFG_DATA_W'(rise);
        vals[REG_FALL_TRIG] = CFG_DATA_W'(fall);
        vals[REG_PORT_SEL]  = CFG_DATA_W'(psel);
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_addr <= t_cfg_reg'(i);
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        int_mask_q  = imask;
        evt_mask_q  = emask;
        rise_trig_q = rise;
        fall_trig_q = fall;
        port_sel_q  = psel;
        @(posedge i_clk);
    endtask

    function automatic logic [LEVELS_W-1:0] all_ports(input logic [LVL_W-1:0] lv);
        return {INPUT_PORTS{lv}};
    endfunction

    task automatic tick(input logic [LEVELS_W-1:0] pins);
        send_item(FUNC_TICK, 16'($urandom), pins);
    endtask

    task automatic clear(input logic [LVL_W-1:0] clr);
        send_item(FUNC_CLEAR, clr, LEVELS_W'({$urandom, $urandom, $urandom, $urandom}));
    endtask

    // levels start low: a high line on the first tick is a rising edge
    task automatic test_first_tick();
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, '0);
        tick(LEVELS_W'(16'hFFFF));
        tick('0);
        clear(16'hFFFF);
        wait_for_results();
    endtask

    task automatic test_port_select();
        logic [LEVELS_W-1:0] spread;
        for (int k = 0; k < INPUT_PORTS; k++)
            spread[k*LVL_W +: LVL_W] = LVL_W'((1 << k) | (1 << (k + 8)));
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 64'h7654_3210_7654_3210);
        tick(spread);
        tick('0);
        tick(all_ports(16'hFFFF));
        clear(16'hFFFF);
        wait_for_results();
        // selects beyond the port count read low
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 64'hFEDC_BA98_FEDC_BA98);
        tick(all_ports(16'hFFFF));
        tick(all_ports(16'hFFFF));
        tick('0);
        wait_for_results();
    endtask

    task automatic test_pending_groups();
        configure(16'hFFFF, 16'hA5A5, 16'hFFFF, 16'h0000, '0);
        tick('0);
        tick(LEVELS_W'(16'h001F));
        tick(LEVELS_W'(16'h03FF));
        clear(16'h001F);
        tick(all_ports(16'hFFFF));
        tick('0);
        tick(all_ports(16'hFFFF));
        clear(16'h0000);
        clear(16'hFFFF);
        wait_for_results();
    endtask

    task automatic send_random_item();
        logic                fn;
        logic [LVL_W-1:0]    clr;
        logic [LEVELS_W-1:0] pins;
        fn  = ($urandom_range(0, 99) < 15) ? FUNC_CLEAR : FUNC_TICK;
        clr = 16'($urandom);
        for (int k = 0; k < INPUT_PORTS; k++)
            pins[k*LVL_W +: LVL_W] = $urandom_range(0, 1) ? 16'($urandom)
                : last_pins[k*LVL_W +: LVL_W] ^ 16'($urandom & $urandom & $urandom);
        if (fn == FUNC_TICK)
            last_pins = pins;
        send_item(fn, clr, pins);
    endtask

    task automatic test_random_traffic();
        logic [PSEL_REG_W-1:0] psel;
        for (int p = 0; p < 6; p++) begin
            psel = {$urandom, $urandom};
            if (p != 2 && p != 3)
                psel = psel & 64'h7777_7777_7777_7777;
            case (p)
                0: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, psel);
                1: configure(16'($urandom), 16'($urandom), 16'hFFFF, 16'h0000, psel);
                2: configure(16'($urandom), 16'($urandom), 16'h0000, 16'hFFFF, psel);
                3: configure(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
                default: configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                                   psel);
            endcase
            calm = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                send_random_item();
                if (p == 4 && i == PHASE_ITEMS / 2)
                    wait_for_results();
            end
            calm = 1'b0;
            wait_for_results();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        rst_n <= 1'b1;
        test_first_tick();
        test_port_select();
        test_pending_groups();
        test_random_traffic();
        wait_for_results();
        if (mismatches == 0 && results_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/exti_pkg.sv
hw/rtl/exti_lane.sv
hw/rtl/exti_merge.sv
hw/rtl/external_interrupt_line_controller.sv
bench/tb.sv
